/* hdl/gsc_pkg.sv */
// ============================================================================
// gsc_pkg
// Types, constants and small helpers shared by the Gromark cipher core.
// ============================================================================
package gsc_pkg;

   localparam int MAX_PERIOD   = 12;
   localparam int LETTERS      = 26;
   localparam int DIGIT_BASE   = 10;
   localparam int LETTER_W     = 5;
   localparam int DIGIT_W      = 4;
   localparam int POS_W        = 4;
   localparam int KEYLEN_W     = 4;
   localparam int OFFSET_COUNT = MAX_PERIOD;
   localparam int PRIMER_COUNT = MAX_PERIOD;
   localparam int ALPHA_W      = LETTERS * LETTER_W;
   localparam int PRIMER_W     = PRIMER_COUNT * DIGIT_W;
   localparam int OFFSETS_W    = OFFSET_COUNT * LETTER_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 60;
   localparam logic [KEYLEN_W-1:0] KEY_LENGTH_RESET = 4'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALPHABET_LOW  = 3'd0,
      CSR_ALPHABET_MID  = 3'd1,
      CSR_ALPHABET_HIGH = 3'd2,
      CSR_PRIMER        = 3'd3,
      CSR_GROUP_OFFSETS = 3'd4,
      CSR_KEY_LENGTH    = 3'd5,
      CSR_PERIODIC      = 3'd6,
      CSR_DECRYPT       = 3'd7
   } gsc_csr_index_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]   alphabet;
      logic [PRIMER_W-1:0]  primer;
      logic [OFFSETS_W-1:0] offsets;
      logic [KEYLEN_W-1:0]  key_length;
      logic                 periodic;
      logic                 decrypt;
   } gsc_cfg_type;

   // one classified request on its way from the front end to the back end
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] shift;
      logic                invalid;
   } gsc_item_type;

   function automatic logic [LETTER_W-1:0] mod26(input logic [LETTER_W-1:0] v);
      logic [LETTER_W-1:0] r;
      r = (v >= LETTER_W'(LETTERS)) ? v - LETTER_W'(LETTERS) : v;
      return r;
   endfunction

   function automatic logic [DIGIT_W-1:0] mod10(input logic [DIGIT_W-1:0] v);
      logic [DIGIT_W-1:0] r;
      r = (v >= DIGIT_W'(DIGIT_BASE)) ? v - DIGIT_W'(DIGIT_BASE) : v;
      return r;
   endfunction

endpackage

/* hdl/gsc_req_if.sv */
// ============================================================================
// gsc_req_if
// Request channel: one letter and its message start flag.
// ============================================================================
interface gsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [gsc_pkg::LETTER_W-1:0]  letter_in;
   logic                          message_start;

   modport source (output valid, output letter_in, output message_start, input ready);
   modport sink   (input valid, input letter_in, input message_start, output ready);
endinterface

/* hdl/gsc_rsp_if.sv */
// ============================================================================
// gsc_rsp_if
// Result channel: one resulting letter and its invalid flag.
// ============================================================================
interface gsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gsc_pkg::LETTER_W-1:0]  letter_out;
   logic                          invalid_letter;

   modport source (output valid, output letter_out, output invalid_letter, input ready);
   modport sink   (input valid, input letter_out, input invalid_letter, output ready);
endinterface

/* hdl/gromark_stream_cipher_core.sv */
// ============================================================================
// gromark_stream_cipher_core
// Gromark cipher, one letter per request, basic or periodic, both directions.
// ============================================================================
// The core takes one letter request per clock cycle while its queue is not
// full, and returns one result per request, in order; each request passes
// through the queue, the back end's first stage and the output register
// before its result is presented. The rate is set by the front end,
// whose running-key window
// (one mod-10 chain addition and a shift) and group counters update once per
// accepted request; a two-entry queue parts it from the two-stage back end,
// which substitutes through the mixed alphabet or, when deciphering, finds
// the lowest alphabet entry that matches and subtracts key digit and group
// offset mod 26. Letters above Z come back as A with invalid_letter set and
// leave the key untouched, though a message start on such a request still
// reloads the primer. Write configuration only while the core is idle.
// ============================================================================
module gromark_stream_cipher_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [gsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gsc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   gsc_req_if.sink                            req,
   gsc_rsp_if.source                          rsp
);
   import gsc_pkg::*;

   logic [59:0]         alphabet_low_ff, alphabet_mid_ff;
   logic [9:0]          alphabet_high_ff;
   logic [PRIMER_W-1:0] primer_ff;
   logic [OFFSETS_W-1:0] offsets_ff;
   logic [KEYLEN_W-1:0] key_length_ff;
   logic                periodic_ff, decrypt_ff;

   gsc_cfg_type  cfg;
   gsc_item_type push_item, head;
   logic         push, pop, full, empty;

   // register file: write only, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_low_ff  <= '0;
         alphabet_mid_ff  <= '0;
         alphabet_high_ff <= '0;
         primer_ff        <= '0;
         offsets_ff       <= '0;
         key_length_ff    <= KEY_LENGTH_RESET;
         periodic_ff      <= 1'b0;
         decrypt_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (gsc_csr_index_type'(csr_index))
            CSR_ALPHABET_LOW:  alphabet_low_ff  <= csr_write_data[59:0];
            CSR_ALPHABET_MID:  alphabet_mid_ff  <= csr_write_data[59:0];
            CSR_ALPHABET_HIGH: alphabet_high_ff <= csr_write_data[9:0];
            CSR_PRIMER:        primer_ff        <= csr_write_data[PRIMER_W-1:0];
            CSR_GROUP_OFFSETS: offsets_ff       <= csr_write_data[OFFSETS_W-1:0];
            CSR_KEY_LENGTH:    key_length_ff    <= csr_write_data[KEYLEN_W-1:0];
            CSR_PERIODIC:      periodic_ff      <= csr_write_data[0];
            CSR_DECRYPT:       decrypt_ff       <= csr_write_data[0];
         endcase
      end
   end

   // gather the alphabet with entry 0 in the lowest bits
   assign cfg.alphabet   = {alphabet_high_ff, alphabet_mid_ff, alphabet_low_ff};
   assign cfg.primer     = primer_ff;
   assign cfg.offsets    = offsets_ff;
   assign cfg.key_length = key_length_ff;
   assign cfg.periodic   = periodic_ff;
   assign cfg.decrypt    = decrypt_ff;

   // front end: accept, advance the running key, classify
   gsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .full      (full),
      .push      (push),
      .push_item (push_item)
   );

   // decouple the two halves so each can stall on its own
   gsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (head),
      .empty     (empty)
   );

   // back end: alphabet substitution and output register
   gsc_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .empty (empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

/* hdl/gsc_front.sv */
// ============================================================================
// gsc_front
// Front end: accept requests, run the chain-addition key and group counters,
// and hand a classified request with its combined shift to the queue.
// ============================================================================
module gsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  gsc_pkg::gsc_cfg_type cfg,
   gsc_req_if.sink              req,
   input  logic                 full,
   output logic                 push,
   output gsc_pkg::gsc_item_type push_item
);
   import gsc_pkg::*;

   logic [DIGIT_W-1:0]  win_ff   [MAX_PERIOD];
   logic [DIGIT_W-1:0]  win_in   [MAX_PERIOD];
   logic [DIGIT_W-1:0]  base_pad [MAX_PERIOD+1];
   logic [POS_W-1:0]    pos_ff, pos_in, grp_ff, grp_in;
   logic [POS_W-1:0]    base_pos, base_grp;
   logic [KEYLEN_W-1:0] period;
   logic [DIGIT_W-1:0]  next_digit;
   logic [DIGIT_W:0]    digit_sum;
   logic [LETTER_W-1:0] off_raw, off;
   logic [LETTER_W:0]   shift_sum;
   logic                invalid;

   assign req.ready = !full;
   assign push      = req.valid && !full;
   assign invalid   = req.letter_in >= LETTER_W'(LETTERS);

   always_comb begin
      // clamp the key length into 1..MAX_PERIOD
      if (cfg.key_length == '0) begin
         period = KEYLEN_W'(1);
      end else if (cfg.key_length > KEYLEN_W'(MAX_PERIOD)) begin
         period = KEYLEN_W'(MAX_PERIOD);
      end else begin
         period = cfg.key_length;
      end

      // reload from the primer before this letter on a message start
      for (int i = 0; i < MAX_PERIOD; i++) begin
         base_pad[i] = req.message_start ? mod10(cfg.primer[i*DIGIT_W +: DIGIT_W]) : win_ff[i];
      end
      base_pad[MAX_PERIOD] = '0;
      base_pos = req.message_start ? '0 : pos_ff;
      base_grp = req.message_start ? '0 : grp_ff;

      off_raw = '0;
      for (int g = 0; g < OFFSET_COUNT; g++) begin
         if (base_grp == POS_W'(g)) begin
            off_raw = cfg.offsets[g*LETTER_W +: LETTER_W];
         end
      end
      off = cfg.periodic ? mod26(off_raw) : '0;

      shift_sum = {2'b00, base_pad[0]} + {1'b0, off};
      push_item.letter  = req.letter_in;
      push_item.invalid = invalid;
      push_item.shift   = (shift_sum >= (LETTER_W+1)'(LETTERS))
                        ? LETTER_W'(shift_sum - (LETTER_W+1)'(LETTERS))
                        : LETTER_W'(shift_sum);

      digit_sum  = {1'b0, base_pad[0]} + {1'b0, base_pad[1]};
      next_digit = (digit_sum >= (DIGIT_W+1)'(DIGIT_BASE))
                 ? DIGIT_W'(digit_sum - (DIGIT_W+1)'(DIGIT_BASE))
                 : DIGIT_W'(digit_sum);

      for (int i = 0; i < MAX_PERIOD; i++) begin
         win_in[i] = base_pad[i];
      end
      pos_in = base_pos;
      grp_in = base_grp;

      if (!invalid) begin
         // shift the first period entries down and append the new digit
         if (period >= KEYLEN_W'(2)) begin
            for (int i = 0; i < MAX_PERIOD; i++) begin
               if ((i + 1) < int'(period)) begin
                  win_in[i] = base_pad[i+1];
               end else if ((i + 1) == int'(period)) begin
                  win_in[i] = next_digit;
               end
            end
         end
         if (({1'b0, base_pos} + 5'd1) >= {1'b0, period}) begin
            pos_in = '0;
            grp_in = (({1'b0, base_grp} + 5'd1) >= {1'b0, period}) ? '0 : base_grp + 1'b1;
         end else begin
            pos_in = base_pos + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PERIOD; i++) begin
            win_ff[i] <= '0;
         end
         pos_ff <= '0;
         grp_ff <= '0;
      end else if (push) begin
         win_ff <= win_in;
         pos_ff <= pos_in;
         grp_ff <= grp_in;
      end
   end

endmodule

/* hdl/gsc_queue.sv */
// ============================================================================
// gsc_queue
// Two-entry queue between the front end and the back end.
// ============================================================================
module gsc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gsc_pkg::gsc_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output gsc_pkg::gsc_item_type pop_item,
   output logic                  empty
);
   import gsc_pkg::*;

   localparam int DEPTH = 2;

   gsc_item_type q_ff [DEPTH];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;

   assign full     = count_ff == 2'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue holds more than its depth");

endmodule

/* hdl/gsc_back.sv */
// ============================================================================
// gsc_back
// Back end: substitute or invert through the mixed alphabet in two stages
// and hold the result in the output register.
// ============================================================================
module gsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  gsc_pkg::gsc_cfg_type  cfg,
   input  logic                  empty,
   input  gsc_pkg::gsc_item_type head,
   output logic                  pop,
   gsc_rsp_if.source             rsp
);
   import gsc_pkg::*;

   logic [LETTER_W-1:0] sig [LETTERS];
   logic                adv;
   logic [LETTER_W:0]   enc_sum;
   logic [LETTER_W-1:0] idx_in, inv, res, sub;
   logic [LETTERS-1:0]  match_in;
   logic [LETTER_W:0]   wrap;

   logic                s1_valid_ff;
   logic [LETTER_W-1:0] s1_idx_ff, s1_shift_ff;
   logic [LETTERS-1:0]  s1_match_ff;
   logic                s1_invalid_ff;
   logic                out_valid_ff;
   logic [LETTER_W-1:0] out_letter_ff;
   logic                out_invalid_ff;

   // whole pipeline moves unless the output register is held
   assign adv = !out_valid_ff || rsp.ready;
   assign pop = adv && !empty;

   always_comb begin
      for (int i = 0; i < LETTERS; i++) begin
         sig[i]      = mod26(cfg.alphabet[i*LETTER_W +: LETTER_W]);
         match_in[i] = sig[i] == head.letter;
      end
      enc_sum = {1'b0, head.letter} + {1'b0, head.shift};
      idx_in  = (enc_sum >= (LETTER_W+1)'(LETTERS))
              ? LETTER_W'(enc_sum - (LETTER_W+1)'(LETTERS))
              : LETTER_W'(enc_sum);
   end

   always_comb begin
      // lowest matching index wins
      inv = '0;
      for (int i = LETTERS - 1; i >= 0; i--) begin
         if (s1_match_ff[i]) begin
            inv = LETTER_W'(i);
         end
      end
      wrap = {1'b0, inv} + (LETTER_W+1)'(LETTERS) - {1'b0, s1_shift_ff};
      sub  = (inv >= s1_shift_ff) ? inv - s1_shift_ff : LETTER_W'(wrap);
      res  = cfg.decrypt ? sub : sig[s1_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff      <= idx_in;
         s1_shift_ff    <= head.shift;
         s1_match_ff    <= match_in;
         s1_invalid_ff  <= head.invalid;
         out_letter_ff  <= s1_invalid_ff ? '0 : res;
         out_invalid_ff <= s1_invalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= !empty;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.letter_out     = out_letter_ff;
   assign rsp.invalid_letter = out_invalid_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result shown straight after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.invalid_letter |-> rsp.letter_out == '0)
      else $error("invalid request gave a non-zero letter");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.letter_out < LETTER_W'(LETTERS))
      else $error("resulting letter out of range");

endmodule
